>>> hw/rtl/http_chunked_body_decoder_defines.svh
// Assertion macros for the chunked body decoder RTL.
// Included by hcbd_decode, which checks its own logic; no other dependencies.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock, off during reset.
`define HCBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hcbd assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define HCBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hcbd assertion failed");

`else

`define HCBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HCBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/hcbd_pkg.sv
// Types, character codes and helpers for the chunked body decoder.
// No dependencies; used by the channel interfaces and imported by all modules.
`timescale 1ns / 1ps

package hcbd_pkg;

	// Item on the input channel.
	typedef struct packed {
		logic [7:0] body_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	// Item on the result channel.
	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [1:0]  outcome;
		logic [31:0] decoded_length;
	} out_item_t;

	// Input register contents handed to the decode stage.
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} stage_t;

	// Outcome codes.
	localparam logic [1:0] OUT_RUNNING    = 2'd0;
	localparam logic [1:0] OUT_COMPLETE   = 2'd1;
	localparam logic [1:0] OUT_MALFORMED  = 2'd2;
	localparam logic [1:0] OUT_INCOMPLETE = 2'd3;

	// Character codes.
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF_A = 8'h66;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LF   = 8'd10;
	localparam logic [7:0] CH_CR   = 8'd13;

	// Hex digit value in the low nibble; bit 4 set when c is no hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd16;
		if (c inside {[CH_0:CH_9]})
			v = c - CH_0;
		else if (c inside {[CH_LA:CH_LF_A]})
			v = c - CH_LA + 8'd10;
		else if (c inside {[CH_UA:CH_UF]})
			v = c - CH_UA + 8'd10;
		return v[4:0];
	endfunction

endpackage

>>> hw/rtl/hcbd_channels.sv
// Valid/ready channel interfaces for the chunked body decoder.
// Depends on hcbd_pkg for the item types.
`timescale 1ns / 1ps

interface hcbd_in_if;
	logic               valid;
	logic               ready;
	hcbd_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hcbd_out_if;
	logic                valid;
	logic                ready;
	hcbd_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/hcbd_in_reg.sv
// Input register of the chunked body decoder: takes one item per cycle while the decode stage moves on.
// Depends on hcbd_pkg and hcbd_channels.
`timescale 1ns / 1ps

module hcbd_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	hcbd_in_if.sink         body,
	input  logic            advance,
	output hcbd_pkg::stage_t s1
);
	import hcbd_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	// Take a new item whenever the held one moves on or the register is empty.
	assign body.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	// Payload holds without reset.
	always_ff @(posedge clk) begin
		if (body.ready && body.valid) begin
			item_s1 <= body.data;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.item  = item_s1;

endmodule

>>> hw/rtl/hcbd_decode.sv
// Decode stage: framing state, one step per item, and the result register.
// Depends on hcbd_pkg, hcbd_channels and the assertion macro header.
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_defines.svh"

module hcbd_decode #(
	parameter int LENGTH_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hcbd_pkg::stage_t s1,
	output logic             advance,
	hcbd_out_if.source       result
);
	import hcbd_pkg::*;

	typedef enum logic [2:0] {
		PH_SIZE = 3'd0,
		PH_SKIP = 3'd1,
		PH_DATA = 3'd2,
		PH_CR   = 3'd3,
		PH_LF   = 3'd4,
		PH_DONE = 3'd5,
		PH_BAD  = 3'd6
	} phase_t;

	phase_t                 phase_q, ph, ph_n;
	logic [LENGTH_BITS-1:0] chunk_q, cnt, cnt_n;
	logic [LENGTH_BITS-1:0] total_q, tot, tot_n;
	logic                   saw_q, saw, saw_n;
	logic                   out_valid_q;
	out_item_t              res_q, res_n;
	logic                   step;
	logic [7:0]             b;
	logic [4:0]             d;

	// Move on when the result register is free or being emptied.
	assign advance = !out_valid_q || result.ready;
	assign step    = s1.valid && advance;
	assign b       = s1.item.body_byte;
	assign d       = hex_value(b);

	// One decode step on the held item.
	always_comb begin
		ph    = s1.item.first_byte ? PH_SIZE : phase_q;
		cnt   = s1.item.first_byte ? '0 : chunk_q;
		tot   = s1.item.first_byte ? '0 : total_q;
		saw   = s1.item.first_byte ? 1'b0 : saw_q;
		ph_n  = ph;
		cnt_n = cnt;
		tot_n = tot;
		saw_n = saw;
		res_n = '0;
		case (ph)
			PH_SIZE: begin
				if (b == CH_CR || b == CH_LF || b == CH_SEMI) begin
					if (!saw)
						ph_n = PH_BAD;
					else if (b == CH_LF)
						ph_n = (cnt == '0) ? PH_DONE : PH_DATA;
					else
						ph_n = PH_SKIP;
				end else if (d[4] || cnt[LENGTH_BITS-1 -: 4] != 4'd0) begin
					ph_n = PH_BAD;
				end else begin
					cnt_n = {cnt[LENGTH_BITS-5:0], d[3:0]};
					saw_n = 1'b1;
				end
			end
			PH_SKIP: begin
				if (b == CH_LF)
					ph_n = (cnt == '0) ? PH_DONE : PH_DATA;
			end
			PH_DATA: begin
				if (&tot) begin
					ph_n = PH_BAD;
				end else begin
					res_n.payload_valid = 1'b1;
					res_n.payload_byte  = b;
					tot_n = tot + 1'b1;
					cnt_n = cnt - 1'b1;
					if (cnt_n == '0)
						ph_n = PH_CR;
				end
			end
			PH_CR: begin
				ph_n = (b == CH_CR) ? PH_LF : PH_BAD;
			end
			PH_LF: begin
				if (b == CH_LF) begin
					ph_n  = PH_SIZE;
					cnt_n = '0;
					saw_n = 1'b0;
				end else begin
					ph_n = PH_BAD;
				end
			end
			PH_DONE: begin
				ph_n = PH_DONE;
			end
			default: begin
				ph_n = PH_BAD;
			end
		endcase

		// Report the outcome after the step.
		if (ph_n == PH_DONE) begin
			res_n.outcome        = OUT_COMPLETE;
			res_n.decoded_length = 32'(tot_n);
		end else if (ph_n == PH_BAD) begin
			res_n.outcome = OUT_MALFORMED;
		end else if (s1.item.last_byte) begin
			res_n.outcome = OUT_INCOMPLETE;
		end else begin
			res_n.outcome = OUT_RUNNING;
		end
	end

	// Hold framing state and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE;
			chunk_q     <= '0;
			total_q     <= '0;
			saw_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= ph_n;
				chunk_q <= cnt_n;
				total_q <= tot_n;
				saw_q   <= saw_n;
			end
			if (advance)
				out_valid_q <= s1.valid;
		end
	end

	// Result payload, loaded with each step.
	always_ff @(posedge clk) begin
		if (step)
			res_q <= res_n;
	end

	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	// A data byte never comes with a complete or malformed status.
	`HCBD_ASSERT_IMP(a_payload_running, clk, arst_n,
		out_valid_q && res_q.payload_valid,
		res_q.outcome == OUT_RUNNING || res_q.outcome == OUT_INCOMPLETE)
	// A length is shown only with a complete body.
	`HCBD_ASSERT_IMP(a_len_complete, clk, arst_n,
		out_valid_q && res_q.outcome != OUT_COMPLETE, res_q.decoded_length == 32'd0)
	// A malformed body stays malformed until a new body starts.
	`HCBD_ASSERT_NXT(a_bad_sticky, clk, arst_n,
		phase_q == PH_BAD && !(step && s1.item.first_byte), phase_q == PH_BAD)
	// Every step leaves a result in the output register.
	`HCBD_ASSERT_NXT(a_step_result, clk, arst_n, step, out_valid_q)

endmodule

>>> hw/rtl/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked body decoder.
// Depends on hcbd_pkg, hcbd_channels, hcbd_in_reg and hcbd_decode.
//
//   channel  dir  item fields
//   body     in   body_byte[8], first_byte, last_byte
//   result   out  payload_valid, payload_byte[8], outcome[2], decoded_length[32]
//
// One byte per clock while result is ready: an item is taken into the input
// register, and a decode step then moves it into the result register, from
// which its result is offered. arst_n clears the framing state to the
// start of a size line. A stalled result holds the decode stage; body ready
// drops in the same cycle once the input register holds an item, and both
// sides resume at full rate when ready returns.
`timescale 1ns / 1ps

module http_chunked_body_decoder #(
	parameter int LENGTH_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	hcbd_in_if.sink    body,
	hcbd_out_if.source result
);
	import hcbd_pkg::*;

	stage_t s1;
	logic   advance;

	// Input register.
	hcbd_in_reg u_in_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.body    (body),
		.advance (advance),
		.s1      (s1)
	);

	// Framing state machine and result register.
	hcbd_decode #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1      (s1),
		.advance (advance),
		.result  (result)
	);

endmodule

>>> tb/hcbd_decode_checker.sv
// Checker for the chunked body decoder: watches the body and result channels,
// predicts each result from the accepted bytes and compares field by field.
// Depends on hcbd_pkg and the channel interfaces in hcbd_channels.
`timescale 1ns / 1ps

module hcbd_decode_checker (
	input  logic clk,
	input  logic arst_n,
	hcbd_in_if   body,
	hcbd_out_if  result,
	output int   errors,
	output int   pending
);
	import hcbd_pkg::*;

	// Framing phases of the decoder.
	typedef enum logic [2:0] {
		FRAME_SIZE,
		FRAME_SKIP,
		FRAME_DATA,
		FRAME_CR,
		FRAME_LF,
		FRAME_DONE,
		FRAME_BAD
	} frame_phase_t;

	localparam logic [31:0] LEN_MAX = '1;

	frame_phase_t phase;
	logic [31:0]  chunk_left;
	logic         saw_digit;
	logic [31:0]  body_total;
	out_item_t    decode_results[$];
	int           fail_count;

	assign errors = fail_count;

	// Return the hex digit value of c, or -1 when c is no hex digit.
	function automatic int digit_of(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return int'(c - CH_0);
		if (c >= CH_LA && c <= CH_LF_A)
			return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF)
			return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	task automatic restart_body();
		phase = FRAME_SIZE;
		chunk_left = '0;
		saw_digit = 1'b0;
		body_total = '0;
	endtask

	// A size line ends at LF: a zero size closes the body.
	task automatic close_size_line();
		if (chunk_left == 0) begin
			phase = FRAME_DONE;
		end else begin
			phase = FRAME_DATA;
		end
	endtask

	// Advance the framing state by one byte and form its result.
	task automatic decode_byte(input in_item_t it, output out_item_t res);
		logic [7:0] b;
		int         d;
		b = it.body_byte;
		res = '0;
		if (it.first_byte)
			restart_body();
		case (phase)
			FRAME_SIZE: begin
				if (b == CH_CR || b == CH_LF || b == CH_SEMI) begin
					if (!saw_digit)
						phase = FRAME_BAD;
					else if (b == CH_LF)
						close_size_line();
					else
						phase = FRAME_SKIP;
				end else begin
					d = digit_of(b);
					if (d < 0 || chunk_left > (LEN_MAX >> 4)) begin
						phase = FRAME_BAD;
					end else begin
						chunk_left = {chunk_left[27:0], d[3:0]};
						saw_digit = 1'b1;
					end
				end
			end
			FRAME_SKIP: begin
				if (b == CH_LF)
					close_size_line();
			end
			FRAME_DATA: begin
				if (body_total == LEN_MAX) begin
					phase = FRAME_BAD;
				end else begin
					res.payload_valid = 1'b1;
					res.payload_byte = b;
					body_total = body_total + 1;
					chunk_left = chunk_left - 1;
					if (chunk_left == 0)
						phase = FRAME_CR;
				end
			end
			FRAME_CR: phase = (b == CH_CR) ? FRAME_LF : FRAME_BAD;
			FRAME_LF: begin
				if (b == CH_LF) begin
					phase = FRAME_SIZE;
					chunk_left = '0;
					saw_digit = 1'b0;
				end else begin
					phase = FRAME_BAD;
				end
			end
			FRAME_DONE: ;
			default: phase = FRAME_BAD;
		endcase

		if (phase == FRAME_DONE) begin
			res.outcome = OUT_COMPLETE;
			res.decoded_length = body_total;
		end else if (phase == FRAME_BAD) begin
			res.outcome = OUT_MALFORMED;
		end else if (it.last_byte) begin
			res.outcome = OUT_INCOMPLETE;
		end else begin
			res.outcome = OUT_RUNNING;
		end
	endtask

	function automatic bit field_ok(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			if (fail_count < 40)
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Compare each accepted result, then predict for each accepted byte.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			restart_body();
			decode_results.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (result.valid && result.ready) begin
				got = result.data;
				if (decode_results.size() == 0) begin
					if (fail_count < 40)
						$display("%0t: result %0h arrived with nothing predicted", $time, got);
					fail_count++;
				end else begin
					want = decode_results.pop_front();
					if (!(field_ok("payload_valid", 32'(want.payload_valid),
							32'(got.payload_valid))
						& field_ok("payload_byte", 32'(want.payload_byte),
							32'(got.payload_byte))
						& field_ok("outcome", 32'(want.outcome), 32'(got.outcome))
						& field_ok("decoded_length", want.decoded_length,
							got.decoded_length)))
						fail_count++;
				end
			end
			if (body.valid && body.ready) begin
				decode_byte(body.data, want);
				decode_results.push_back(want);
			end
			pending <= decode_results.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the chunked body decoder bench: clock, reset, byte stimulus and the
// verdict. Depends on hcbd_pkg, hcbd_channels, the decoder RTL and the checker.
`timescale 1ns / 1ps

module testbench;
	import hcbd_pkg::*;

	localparam int RANDOM_ITEMS = 400;
	localparam int CALM_ITEMS   = 340;
	localparam int CYCLE_LIMIT  = 200000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   sent_count;
	int   calm_at;
	int   random_base;
	int   cycle_count;
	bit   calm;

	logic [7:0] body_text[$];

	hcbd_in_if  body();
	hcbd_out_if result();

	http_chunked_body_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body),
		.result (result)
	);

	hcbd_decode_checker watch (
		.clk     (clk),
		.arst_n  (arst_n),
		.body    (body),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// End the run if it hangs.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL http_chunked_body_decoder");
			$finish;
		end
	end

	// Stall the result side in bursts; hold ready high once the run calms.
	initial begin
		result.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				result.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 10)
			return CH_0 + 8'(n);
		return (upper ? CH_UA : CH_LA) + 8'(n) - 8'd10;
	endfunction

	task automatic add_text(input string s);
		foreach (s[i])
			body_text.push_back(s[i]);
	endtask

	task automatic add_crlf();
		body_text.push_back(CH_CR);
		body_text.push_back(CH_LF);
	endtask

	// Append any byte except LF, as found inside an extension.
	task automatic add_junk(input int count);
		logic [7:0] b;
		repeat (count) begin
			b = 8'($urandom_range(0, 255));
			body_text.push_back((b == CH_LF) ? CH_SEMI : b);
		end
	endtask

	// Append a size line: optional leading zeros, hex digits, then one of
	// the ways a line may end.
	task automatic add_size_line(input logic [31:0] size);
		logic [7:0] digs[$];
		bit         upper;
		upper = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) body_text.push_back(CH_0);
		do begin
			digs.push_front(hex_char(size[3:0], upper));
			size = size >> 4;
		end while (size != 0);
		foreach (digs[i])
			body_text.push_back(digs[i]);
		case ($urandom_range(0, 5))
			0: begin
				body_text.push_back(CH_SEMI);
				add_junk($urandom_range(0, 5));
				add_crlf();
			end
			1: body_text.push_back(CH_LF);
			2: begin
				body_text.push_back(CH_CR);
				add_junk($urandom_range(0, 3));
				body_text.push_back(CH_LF);
			end
			default: add_crlf();
		endcase
	endtask

	// Build a well-formed body: a few chunks, the last chunk, maybe trailers.
	task automatic build_good_body();
		int size;
		repeat ($urandom_range(0, 3)) begin
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
				: $urandom_range(1, 16);
			add_size_line(size);
			repeat (size) body_text.push_back(8'($urandom_range(0, 255)));
			add_crlf();
		end
		add_size_line(0);
		if ($urandom_range(0, 2) == 0)
			add_junk($urandom_range(1, 6));
	endtask

	// Send the built body one item at a time and clear it.
	task automatic send_body(input bit with_first, input int last_pos,
		input bit stray_last);
		in_item_t it;
		bit       quiet;
		quiet = ($urandom_range(0, 2) == 0);
		foreach (body_text[i]) begin
			it.body_byte = body_text[i];
			it.first_byte = with_first && (i == 0);
			it.last_byte = (i == last_pos) || (stray_last && $urandom_range(0, 39) == 0);
			calm = (sent_count >= calm_at);
			if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
				body.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			body.valid <= 1'b1;
			body.data <= it;
			do @(posedge clk); while (!body.ready);
			sent_count++;
		end
		body_text.delete();
	endtask

	initial begin
		int n;
		int pos;
		arst_n <= 1'b0;
		body.valid <= 1'b0;
		body.data <= '0;
		sent_count = 0;
		calm_at = 32'h7fff_ffff;
		calm = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero size ends the body at once; a trailer byte repeats complete.
		add_text("0");
		add_crlf();
		body_text.push_back(8'hFF);
		send_body(1'b1, 3, 1'b0);
		// Non-hex digit, then a byte while malformed.
		add_text("g");
		body_text.push_back(8'h00);
		send_body(1'b1, -1, 1'b0);
		// Empty size line.
		body_text.push_back(CH_CR);
		send_body(1'b1, -1, 1'b0);
		// Early end on a size digit, bare extension, data, then missing CR.
		add_text("1;");
		body_text.push_back(CH_LF);
		add_text("ZX");
		send_body(1'b1, 0, 1'b0);
		// Size overflow on the ninth digit.
		add_text("fFfFfFfFf");
		send_body(1'b1, 8, 1'b0);

		// Mostly well-formed bodies with random content, some broken ones.
		random_base = sent_count;
		calm_at = random_base + CALM_ITEMS;
		while (sent_count - random_base < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				6: begin
					build_good_body();
					pos = $urandom_range(0, body_text.size() - 1);
					body_text[pos] = 8'($urandom_range(0, 255));
					send_body(1'b1, body_text.size() - 1, 1'b1);
				end
				7: begin
					build_good_body();
					n = $urandom_range(1, body_text.size());
					while (body_text.size() > n)
						void'(body_text.pop_back());
					send_body(1'b1, n - 1, 1'b0);
				end
				8: begin
					body_text.push_back(hex_char(4'($urandom_range(1, 15)),
						1'($urandom_range(0, 1))));
					repeat ($urandom_range(8, 9))
						body_text.push_back(hex_char(4'($urandom_range(0, 15)),
							1'($urandom_range(0, 1))));
					add_crlf();
					add_junk($urandom_range(0, 4));
					send_body(1'b1, body_text.size() - 1, 1'b0);
				end
				9: begin
					n = $urandom_range(1, 8);
					repeat (n) body_text.push_back(8'($urandom_range(0, 255)));
					send_body(1'($urandom_range(0, 1)), $urandom_range(0, n), 1'b1);
				end
				default: begin
					build_good_body();
					send_body($urandom_range(0, 9) != 0, body_text.size() - 1, 1'b1);
				end
			endcase
		end
		body.valid <= 1'b0;

		// Drain the outstanding results, then allow for the pipeline.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS http_chunked_body_decoder");
		else
			$display("FAIL http_chunked_body_decoder");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_channels.sv
hw/rtl/hcbd_in_reg.sv
hw/rtl/hcbd_decode.sv
hw/rtl/http_chunked_body_decoder.sv
tb/hcbd_decode_checker.sv
tb/testbench.sv
